// ===== hdl/udfu_pkg.sv =====
// Shared types, codes and helpers of the DFU request state machine.
package udfu_pkg;

  localparam int XFER_SIZE = 1024;
  localparam int XFER_LOG2 = $clog2(XFER_SIZE);
  localparam int LEN_W     = 11;

  localparam logic [31:0] BASE_RESET = 32'h0800_4000;
  localparam logic [23:0] TIME_RESET = 24'd50;

  localparam logic [LEN_W-1:0] REPLY_STATUS  = LEN_W'(6);
  localparam logic [LEN_W-1:0] REPLY_STATE   = LEN_W'(1);
  localparam logic [LEN_W-1:0] REPLY_CMDLIST = LEN_W'(3);
  localparam logic [LEN_W-1:0] SPECIAL_LEN   = LEN_W'(5);

  localparam logic [3:0] STAT_OK      = 4'd0;
  localparam logic [3:0] STAT_UNKNOWN = 4'd1;
  localparam logic [3:0] STAT_STALLED = 4'd2;

  localparam logic [7:0] CMD_SETPTR = 8'h21;
  localparam logic [7:0] CMD_ERASE  = 8'h41;

  typedef enum logic [2:0] {
    OP_DETACH    = 3'd0,
    OP_DNLOAD    = 3'd1,
    OP_UPLOAD    = 3'd2,
    OP_GETSTATUS = 3'd3,
    OP_CLRSTATUS = 3'd4,
    OP_GETSTATE  = 3'd5,
    OP_ABORT     = 3'd6,
    OP_BUS_RESET = 3'd7
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'd2,
    ST_DN_SYNC  = 4'd3,
    ST_DN_BUSY  = 4'd4,
    ST_DN_IDLE  = 4'd5,
    ST_MAN_SYNC = 4'd6,
    ST_MANIFEST = 4'd7,
    ST_MAN_WAIT = 4'd8,
    ST_UP_IDLE  = 4'd9,
    ST_ERROR    = 4'd10
  } dfu_state_t;

  typedef enum logic [1:0] {
    FOP_NONE  = 2'd0,
    FOP_WRITE = 2'd1,
    FOP_ERASE = 2'd2,
    FOP_READ  = 2'd3
  } flash_op_t;

  typedef enum logic [1:0] {
    CFG_BASE      = 2'd0,
    CFG_PROG_TIME = 2'd1,
    CFG_ERASE_TIME = 2'd2,
    CFG_TOLERANT  = 2'd3
  } cfg_idx_t;

  // Classified request as it travels from front to back.
  typedef struct packed {
    op_t              op;
    logic [15:0]      blk;
    logic             blk_is0;
    logic             blk_is1;
    logic             len_zero;
    logic [LEN_W-1:0] len;
    logic             len_gt3;
    logic [7:0]       cbyte;
    logic [31:0]      carg;
    logic [31:0]      up_offset;
  } req_t;

  typedef struct packed {
    logic             rej;
    logic             leave;
    logic             clist;
    logic [LEN_W-1:0] flen;
    logic [31:0]      faddr;
    flash_op_t        fop;
    logic [3:0]       state;
    logic [23:0]      tmo;
    logic [3:0]       stat;
    logic [LEN_W-1:0] reply;
  } result_t;

  // Byte offset of a firmware block from the address pointer.
  function automatic logic [31:0] blk_offset(input logic [15:0] blk);
    logic [31:0] rel;
    rel = {16'd0, blk} - 32'd2;
    return rel << XFER_LOG2;
  endfunction

endpackage

// ===== hdl/udfu_front.sv =====
// Request intake: unpacks the slave stream and classifies each request.
module udfu_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [71:0]         s_tdata,   // block_number, request_length, command_byte,
                                         // command_address
  input  logic [2:0]          s_tuser,   // opcode
  output logic                push,
  output udfu_pkg::req_t      push_req,
  input  logic                q_ready
);

  logic           valid;
  udfu_pkg::req_t req;
  udfu_pkg::req_t req_next;
  logic [15:0]    rlen;

  assign rlen = s_tdata[31:16];

  always_comb begin
    req_next.op        = udfu_pkg::op_t'(s_tuser);
    req_next.blk       = s_tdata[15:0];
    req_next.blk_is0   = (s_tdata[15:0] == 16'd0);
    req_next.blk_is1   = (s_tdata[15:0] == 16'd1);
    req_next.len_zero  = (rlen == 16'd0);
    if (rlen > 16'(udfu_pkg::XFER_SIZE)) begin
      req_next.len = udfu_pkg::LEN_W'(udfu_pkg::XFER_SIZE);
    end else begin
      req_next.len = rlen[udfu_pkg::LEN_W-1:0];
    end
    req_next.len_gt3   = (rlen > 16'd3);
    req_next.cbyte     = s_tdata[39:32];
    req_next.carg      = s_tdata[71:40];
    req_next.up_offset = udfu_pkg::blk_offset(s_tdata[15:0]);
  end

  assign s_tready = !valid || q_ready;
  assign push     = valid && q_ready;
  assign push_req = req;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      valid <= 1'b1;
    end else if (push) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req <= req_next;
    end
  end

endmodule

// ===== hdl/udfu_queue.sv =====
// Short request queue between the intake and the state machine.
module udfu_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  udfu_pkg::req_t push_req,
  output logic           q_ready,
  input  logic           pop,
  output logic           q_valid,
  output udfu_pkg::req_t q_req
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  udfu_pkg::req_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_ready = (count != CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign q_req   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_req;
    end
  end

endmodule

// ===== hdl/udfu_back.sv =====
// DFU state machine: executes queued requests and holds the result register.
module udfu_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  udfu_pkg::req_t q_req,
  output logic           pop,
  input  logic           cfg_valid,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  output logic           m_tvalid,
  input  logic           m_tready,
  output udfu_pkg::result_t res
);

  localparam int LW = udfu_pkg::LEN_W;

  // configuration
  logic [31:0] base_address;
  logic [23:0] program_time;
  logic [23:0] erase_time;
  logic        manifest_tolerant;

  // protocol state
  udfu_pkg::dfu_state_t state, state_next;
  logic          mpend, mpend_next;
  logic [15:0]   lblk, lblk_next;
  logic [LW-1:0] llen, llen_next;
  logic [31:0]   aptr, aptr_next;
  logic [7:0]    pcmd, pcmd_next;
  logic [31:0]   parg, parg_next;
  logic          wpend, wpend_next;
  logic [3:0]    stat, stat_next;
  logic [23:0]   tmo, tmo_next;

  udfu_pkg::result_t res_next;
  udfu_pkg::dfu_state_t snap_state;
  logic [23:0]   snap_tmo;
  logic          snap;
  logic          early;
  logic          stuck;
  logic          idle_like;
  logic [31:0]   dn_addr;

  assign pop = q_valid && (!m_tvalid || m_tready);

  assign idle_like = (state == udfu_pkg::ST_IDLE) || (state == udfu_pkg::ST_DN_SYNC) ||
                     (state == udfu_pkg::ST_DN_IDLE) || (state == udfu_pkg::ST_MAN_SYNC) ||
                     (state == udfu_pkg::ST_UP_IDLE);

  assign dn_addr = udfu_pkg::blk_offset(lblk) + aptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address      <= udfu_pkg::BASE_RESET;
      program_time      <= udfu_pkg::TIME_RESET;
      erase_time        <= udfu_pkg::TIME_RESET;
      manifest_tolerant <= 1'b1;
    end else if (cfg_valid) begin
      case (udfu_pkg::cfg_idx_t'(cfg_index))
        udfu_pkg::CFG_BASE:       base_address      <= cfg_data;
        udfu_pkg::CFG_PROG_TIME:  program_time      <= cfg_data[23:0];
        udfu_pkg::CFG_ERASE_TIME: erase_time        <= cfg_data[23:0];
        udfu_pkg::CFG_TOLERANT:   manifest_tolerant <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    mpend_next = mpend;
    lblk_next  = lblk;
    llen_next  = llen;
    aptr_next  = aptr;
    pcmd_next  = pcmd;
    parg_next  = parg;
    wpend_next = wpend;
    stat_next  = stat;
    tmo_next   = tmo;
    snap       = 1'b0;
    snap_state = state;
    snap_tmo   = tmo;
    early      = 1'b0;
    stuck      = 1'b0;
    res_next   = '0;
    res_next.fop = udfu_pkg::FOP_NONE;

    if (pop) begin
      case (q_req.op)
        udfu_pkg::OP_DETACH, udfu_pkg::OP_ABORT: begin
          if (idle_like) begin
            state_next = udfu_pkg::ST_IDLE;
            stat_next  = udfu_pkg::STAT_OK;
            tmo_next   = '0;
            lblk_next  = '0;
            llen_next  = '0;
          end else begin
            res_next.rej = 1'b1;
          end
        end
        udfu_pkg::OP_DNLOAD: begin
          if (!q_req.len_zero) begin
            if (state == udfu_pkg::ST_IDLE || state == udfu_pkg::ST_DN_IDLE) begin
              lblk_next  = q_req.blk;
              llen_next  = q_req.len;
              pcmd_next  = q_req.cbyte;
              parg_next  = q_req.carg;
              state_next = udfu_pkg::ST_DN_SYNC;
              wpend_next = 1'b1;
            end else begin
              res_next.rej = 1'b1;
            end
          end else if (state == udfu_pkg::ST_IDLE || state == udfu_pkg::ST_DN_IDLE) begin
            mpend_next = 1'b1;
            state_next = udfu_pkg::ST_MAN_SYNC;
            tmo_next   = '0;
          end else begin
            res_next.rej = 1'b1;
          end
        end
        udfu_pkg::OP_UPLOAD: begin
          if (q_req.len_zero) begin
            state_next = udfu_pkg::ST_IDLE;
            tmo_next   = '0;
          end else if (state == udfu_pkg::ST_IDLE || state == udfu_pkg::ST_UP_IDLE) begin
            lblk_next = q_req.blk;
            llen_next = q_req.len;
            tmo_next  = '0;
            if (q_req.blk_is0) begin
              state_next     = q_req.len_gt3 ? udfu_pkg::ST_IDLE : udfu_pkg::ST_UP_IDLE;
              res_next.reply = udfu_pkg::REPLY_CMDLIST;
              res_next.clist = 1'b1;
            end else if (!q_req.blk_is1) begin
              state_next     = udfu_pkg::ST_UP_IDLE;
              res_next.fop   = udfu_pkg::FOP_READ;
              res_next.faddr = q_req.up_offset + aptr;
              res_next.flen  = q_req.len;
              res_next.reply = q_req.len;
            end else begin
              state_next   = udfu_pkg::ST_ERROR;
              stat_next    = udfu_pkg::STAT_STALLED;
              res_next.rej = 1'b1;
            end
          end else begin
            lblk_next    = '0;
            llen_next    = '0;
            res_next.rej = 1'b1;
          end
        end
        udfu_pkg::OP_GETSTATUS: begin
          // end of manifestation
          if (mpend && state == udfu_pkg::ST_MAN_SYNC && tmo == '0) begin
            mpend_next = 1'b0;
            tmo_next   = '0;
            if (manifest_tolerant) begin
              state_next = udfu_pkg::ST_MAN_SYNC;
              early      = 1'b1;
            end else begin
              state_next     = udfu_pkg::ST_MAN_WAIT;
              res_next.leave = 1'b1;
            end
          end
          if (!early) begin
            if (state_next == udfu_pkg::ST_DN_SYNC) begin
              if (llen != '0) begin
                state_next = udfu_pkg::ST_DN_BUSY;
                if (lblk == 16'd0 && pcmd == udfu_pkg::CMD_ERASE) begin
                  tmo_next = erase_time;
                end else begin
                  tmo_next = program_time;
                end
              end else begin
                state_next = udfu_pkg::ST_DN_IDLE;
                tmo_next   = '0;
              end
            end else if (state_next == udfu_pkg::ST_MAN_SYNC) begin
              if (mpend_next) begin
                state_next = udfu_pkg::ST_MANIFEST;
                tmo_next   = 24'd1;
              end else if (manifest_tolerant) begin
                state_next = udfu_pkg::ST_IDLE;
                tmo_next   = '0;
              end
            end
          end
          // reply carries the status before the pending write runs
          snap           = 1'b1;
          snap_state     = state_next;
          snap_tmo       = tmo_next;
          res_next.reply = udfu_pkg::REPLY_STATUS;
          if (!early && wpend) begin
            if (state_next == udfu_pkg::ST_DN_BUSY) begin
              if (lblk == 16'd0) begin
                if (llen == udfu_pkg::SPECIAL_LEN) begin
                  if (pcmd == udfu_pkg::CMD_SETPTR) begin
                    aptr_next = parg;
                  end else if (pcmd == udfu_pkg::CMD_ERASE) begin
                    aptr_next      = parg;
                    res_next.fop   = udfu_pkg::FOP_ERASE;
                    res_next.faddr = parg;
                  end else begin
                    stuck = 1'b1;
                  end
                end
              end else if (lblk > 16'd1) begin
                res_next.fop   = udfu_pkg::FOP_WRITE;
                res_next.faddr = dn_addr;
                res_next.flen  = llen;
              end
              if (!stuck) begin
                llen_next  = '0;
                lblk_next  = '0;
                state_next = udfu_pkg::ST_DN_SYNC;
                tmo_next   = '0;
              end
            end
            wpend_next = 1'b0;
          end
        end
        udfu_pkg::OP_CLRSTATUS: begin
          if (state == udfu_pkg::ST_ERROR) begin
            state_next = udfu_pkg::ST_IDLE;
            stat_next  = udfu_pkg::STAT_OK;
          end else begin
            state_next   = udfu_pkg::ST_ERROR;
            stat_next    = udfu_pkg::STAT_UNKNOWN;
            res_next.rej = 1'b1;
          end
          tmo_next = '0;
        end
        udfu_pkg::OP_GETSTATE: begin
          res_next.reply = udfu_pkg::REPLY_STATE;
        end
        udfu_pkg::OP_BUS_RESET: begin
          state_next = udfu_pkg::ST_IDLE;
          mpend_next = 1'b0;
          lblk_next  = '0;
          llen_next  = '0;
          aptr_next  = base_address;
          pcmd_next  = '0;
          parg_next  = '0;
          wpend_next = 1'b0;
          stat_next  = udfu_pkg::STAT_OK;
          tmo_next   = '0;
        end
        default: ;
      endcase
    end

    res_next.stat = stat_next;
    if (snap) begin
      res_next.tmo   = snap_tmo;
      res_next.state = snap_state;
    end else begin
      res_next.tmo   = tmo_next;
      res_next.state = state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= udfu_pkg::ST_IDLE;
      mpend    <= 1'b0;
      lblk     <= '0;
      llen     <= '0;
      aptr     <= udfu_pkg::BASE_RESET;
      pcmd     <= '0;
      parg     <= '0;
      wpend    <= 1'b0;
      stat     <= udfu_pkg::STAT_OK;
      tmo      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      mpend <= mpend_next;
      lblk  <= lblk_next;
      llen  <= llen_next;
      aptr  <= aptr_next;
      pcmd  <= pcmd_next;
      parg  <= parg_next;
      wpend <= wpend_next;
      stat  <= stat_next;
      tmo   <= tmo_next;
      if (pop) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_reset_idle: assert property (@(posedge clk) rst |=> state == udfu_pkg::ST_IDLE && !m_tvalid)
    else $error("state machine not idle after reset");
  a_bus_reset: assert property (@(posedge clk) disable iff (rst)
    pop && q_req.op == udfu_pkg::OP_BUS_RESET |=> state == udfu_pkg::ST_IDLE && !wpend
      && aptr == $past(base_address))
    else $error("bus reset did not restore state");
  a_flash_not_rejected: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.fop != udfu_pkg::FOP_NONE |-> !res.rej)
    else $error("flash command issued on a rejected request");
  a_erase_no_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.fop == udfu_pkg::FOP_ERASE |-> res.flen == '0)
    else $error("erase carries a length");
  a_no_pop_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !pop)
    else $error("result overwritten while stalled");
`endif

endmodule

// ===== hdl/usb_dfu_request_state_machine.sv =====
// Top level of the DFU request state machine.
//
// Requests enter on the s_ stream (opcode in s_tuser, setup and payload
// arguments in s_tdata); one result per request leaves on the m_ stream in
// request order. Configuration registers (base address, program and erase
// poll timeouts, manifestation tolerance) are written on the cfg_ channel,
// which is always ready; write them only while no request is in flight.
// A request passes the intake register, the queue and the state-machine
// result register before its result is valid on the m_ stream. Throughput:
// one request per cycle sustained while the receiver takes results; the
// state machine updates all protocol state once per request, which sets
// the rate.
// When the receiver stalls, the result register holds, the queue fills
// and the intake register fills, then s_tready falls; nothing is dropped.
// Reset (rst, synchronous) empties the intake register and the queue, drops
// any held result, returns the configuration to its defaults and the device
// to dfuIDLE with the address pointer at the default base address.
module usb_dfu_request_state_machine #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // block_number, request_length, command_byte,
                                 // command_address
  input  logic [2:0]  s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // reply_length, status_code, poll_timeout,
                                 // device_state, flash_op, flash_address,
                                 // flash_length, leave_request, request_rejected
  output logic [0:0]  m_tuser,   // command_list
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic              push;
  udfu_pkg::req_t    push_req;
  logic              q_ready;
  logic              pop;
  logic              q_valid;
  udfu_pkg::req_t    q_req;
  udfu_pkg::result_t res;

  assign cfg_ready = 1'b1;

  udfu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .push     (push),
    .push_req (push_req),
    .q_ready  (q_ready)
  );

  udfu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .q_ready  (q_ready),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_req    (q_req)
  );

  udfu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .pop       (pop),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .res       (res)
  );

  assign m_tdata = {6'd0, res.rej, res.leave, res.flen, res.faddr, res.fop,
                    res.state, res.tmo, res.stat, res.reply};
  assign m_tuser = res.clist;

endmodule
